// ===== rtl/srt_pkg.sv =====
// Shared types and constants for the segment reorder tracker.
// No dependencies; imported by the top level.
package srt_pkg;

   localparam int DEFAULT_ENTRIES = 16;
   localparam int SEQ_W = 32;
   localparam int LEN_W = 11;
   localparam int HND_W = 8;
   localparam int ENTRY_W = SEQ_W + LEN_W + HND_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLASSIFY,
      ST_SCAN,
      ST_SHIFT_PRE,
      ST_SHIFT,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic             deliver;
      logic [HND_W-1:0] handle;
      logic [LEN_W-1:0] length;
      logic [SEQ_W-1:0] ack;
      logic             dropped;
   } result_type;

endpackage

// ===== rtl/segment_reorder_tracker_unit.sv =====
// Segment reorder tracker: top level with the sequencer and the shared datapath.
// Depends on srt_pkg and srt_ram.
//
// Each request is one received segment descriptor. The block keeps the next
// expected sequence and a circular table of up to ENTRIES out-of-order segments
// sorted by distance ahead of it, held in one RAM with a single read port. An
// end-of-file marker, an old segment or a segment that finds the table full goes
// straight to its result without touching the table. An in-order segment is
// delivered, and every stored segment at the head that is now in order or old
// is delivered or discarded in turn. A duplicate is found by comparing it with
// each stored entry. A segment that is stored is first compared with each stored
// entry, and then the entries from its place onward are moved up one by one to
// make room. A result that waits on the output stalls the block. The RAM read
// port is used once per cycle. The block takes one request at a time; the output
// register lets the last result wait while the next request is accepted.
module segment_reorder_tracker_unit #(
   parameter int ENTRIES = srt_pkg::DEFAULT_ENTRIES
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [srt_pkg::SEQ_W-1:0] req_seq_num,
   input  logic [srt_pkg::LEN_W-1:0] req_seg_length,
   input  logic [srt_pkg::HND_W-1:0] req_buffer_handle,
   input  logic                      req_is_eof,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_deliver,
   output logic [srt_pkg::HND_W-1:0] rsp_out_handle,
   output logic [srt_pkg::LEN_W-1:0] rsp_out_length,
   output logic [srt_pkg::SEQ_W-1:0] rsp_ack_seq,
   output logic                      rsp_dropped,
   output logic                      rsp_done_res,
   output logic                      rsp_last
);

   import srt_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);

   function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] base,
                                             input logic [CNT_W-1:0] off);
      logic [CNT_W:0] sum;
      sum = {{(CNT_W + 1 - IDX_W){1'b0}}, base} + {1'b0, off};
      if (sum >= (CNT_W + 1)'(ENTRIES)) begin
         sum = sum - (CNT_W + 1)'(ENTRIES);
      end
      return sum[IDX_W-1:0];
   endfunction

   state_type        state_ff, state_in;
   logic [SEQ_W-1:0] expected_ff, expected_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic             eof_seen_ff, eof_seen_in;
   logic [SEQ_W-1:0] eof_point_ff, eof_point_in;

   logic [SEQ_W-1:0] in_seq_ff, in_seq_in;
   logic [LEN_W-1:0] in_len_ff, in_len_in;
   logic [HND_W-1:0] in_hnd_ff, in_hnd_in;
   logic             in_eof_ff, in_eof_in;
   logic [SEQ_W-1:0] dist_ff, dist_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0] sh_ff, sh_in;
   logic             found_ff, found_in;
   logic             dup_ff, dup_in;
   result_type       pend_ff, pend_in;

   result_type       rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_last_ff, rsp_last_in;
   logic             rsp_done_ff, rsp_done_in;

   logic               out_free;
   logic [SEQ_W-1:0]   sub_a, diff, sum;
   logic [LEN_W-1:0]   add_b;
   logic               scan_gt, scan_eq, scan_end;
   logic [IDX_W-1:0]   head_inc;
   logic [CNT_W-1:0]   rd_off;
   logic [IDX_W-1:0]   rd_addr, wr_addr;
   logic               wr_en;
   logic [ENTRY_W-1:0] wr_data, rd_data;
   logic [SEQ_W-1:0]   rd_seq;
   logic [LEN_W-1:0]   rd_len;
   logic [HND_W-1:0]   rd_hnd;

   srt_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(ENTRIES)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign rd_seq = rd_data[ENTRY_W-1 -: SEQ_W];
   assign rd_len = rd_data[HND_W +: LEN_W];
   assign rd_hnd = rd_data[HND_W-1:0];

   // Shared sequence unit: one subtractor for the wrap-aware compares and one
   // adder that advances the expected sequence.
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign sub_a    = (state_ff == ST_CLASSIFY) ? in_seq_ff : rd_seq;
   assign diff     = sub_a - expected_ff;
   assign add_b    = (state_ff == ST_CLASSIFY) ? in_len_ff : rd_len;
   assign sum      = expected_ff + SEQ_W'(add_b);
   assign scan_gt  = diff > dist_ff;
   assign scan_eq  = rd_seq == in_seq_ff;
   assign scan_end = idx_ff == count_ff - 1'b1;
   assign head_inc = (head_ff == IDX_W'(ENTRIES - 1)) ? '0 : head_ff + 1'b1;
   assign rd_addr  = phys(head_in, rd_off);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_CLASSIFY;
            end
         end
         ST_CLASSIFY: begin
            if (in_eof_ff || diff[SEQ_W-1]) begin
               state_in = ST_FINISH;
            end else if (diff == '0) begin
               state_in = ST_DRAIN;
            end else if (count_ff == CNT_W'(ENTRIES)) begin
               state_in = ST_FINISH;
            end else if (count_ff == '0) begin
               state_in = ST_SHIFT_PRE;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_end) begin
               state_in = (dup_ff || scan_eq) ? ST_FINISH : ST_SHIFT_PRE;
            end
         end
         ST_SHIFT_PRE: begin
            state_in = ST_SHIFT;
         end
         ST_SHIFT: begin
            if (sh_ff == pos_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_DRAIN: begin
            if (count_ff == '0) begin
               state_in = ST_FINISH;
            end else if (diff != '0 && !diff[SEQ_W-1]) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready    = state_ff == ST_IDLE;
      expected_in  = expected_ff;
      count_in     = count_ff;
      head_in      = head_ff;
      eof_seen_in  = eof_seen_ff;
      eof_point_in = eof_point_ff;
      in_seq_in    = in_seq_ff;
      in_len_in    = in_len_ff;
      in_hnd_in    = in_hnd_ff;
      in_eof_in    = in_eof_ff;
      dist_in      = dist_ff;
      idx_in       = idx_ff;
      pos_in       = pos_ff;
      sh_in        = sh_ff;
      found_in     = found_ff;
      dup_in       = dup_ff;
      pend_in      = pend_ff;
      rsp_in       = rsp_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_done_in  = rsp_done_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rd_off       = '0;
      wr_en        = 1'b0;
      wr_addr      = phys(head_ff, sh_ff);
      wr_data      = rd_data;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               in_seq_in = req_seq_num;
               in_len_in = req_seg_length;
               in_hnd_in = req_buffer_handle;
               in_eof_in = req_is_eof;
            end
         end
         ST_CLASSIFY: begin
            dist_in         = diff;
            idx_in          = '0;
            pos_in          = count_ff;
            found_in        = 1'b0;
            dup_in          = 1'b0;
            pend_in.deliver = 1'b0;
            pend_in.handle  = '0;
            pend_in.length  = '0;
            pend_in.ack     = expected_ff;
            pend_in.dropped = 1'b0;
            if (in_eof_ff) begin
               eof_seen_in  = 1'b1;
               eof_point_in = in_seq_ff;
            end else if (diff[SEQ_W-1]) begin
               pend_in.dropped = 1'b1;
            end else if (diff == '0) begin
               expected_in     = sum;
               pend_in.deliver = 1'b1;
               pend_in.handle  = in_hnd_ff;
               pend_in.length  = in_len_ff;
               pend_in.ack     = sum;
            end else if (count_ff == CNT_W'(ENTRIES)) begin
               pend_in.dropped = 1'b1;
            end
         end
         ST_SCAN: begin
            if (!found_ff && scan_gt) begin
               pos_in   = idx_ff;
               found_in = 1'b1;
            end
            if (scan_eq) begin
               dup_in = 1'b1;
            end
            idx_in = idx_ff + 1'b1;
            rd_off = idx_ff + 1'b1;
            if (scan_end && (dup_ff || scan_eq)) begin
               pend_in.dropped = 1'b1;
            end
         end
         ST_SHIFT_PRE: begin
            sh_in  = count_ff;
            rd_off = (count_ff == '0) ? '0 : count_ff - 1'b1;
         end
         ST_SHIFT: begin
            wr_en = 1'b1;
            if (sh_ff == pos_ff) begin
               wr_data  = {in_seq_ff, in_len_ff, in_hnd_ff};
               count_in = count_ff + 1'b1;
            end else begin
               sh_in  = sh_ff - 1'b1;
               rd_off = (sh_ff >= CNT_W'(2)) ? sh_ff - CNT_W'(2) : '0;
            end
         end
         ST_DRAIN: begin
            if (count_ff != '0) begin
               if (diff == '0) begin
                  if (out_free) begin
                     rsp_in          = pend_ff;
                     rsp_last_in     = 1'b0;
                     rsp_done_in     = 1'b0;
                     rsp_valid_in    = 1'b1;
                     pend_in.deliver = 1'b1;
                     pend_in.handle  = rd_hnd;
                     pend_in.length  = rd_len;
                     pend_in.ack     = sum;
                     pend_in.dropped = 1'b0;
                     expected_in     = sum;
                     head_in         = head_inc;
                     count_in        = count_ff - 1'b1;
                  end
               end else if (diff[SEQ_W-1]) begin
                  head_in  = head_inc;
                  count_in = count_ff - 1'b1;
               end
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_in       = pend_ff;
               rsp_last_in  = 1'b1;
               rsp_done_in  = eof_seen_ff && (expected_ff == eof_point_ff);
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         expected_ff  <= '0;
         count_ff     <= '0;
         head_ff      <= '0;
         eof_seen_ff  <= 1'b0;
         eof_point_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         expected_ff  <= expected_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         eof_seen_ff  <= eof_seen_in;
         eof_point_ff <= eof_point_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_seq_ff   <= in_seq_in;
      in_len_ff   <= in_len_in;
      in_hnd_ff   <= in_hnd_in;
      in_eof_ff   <= in_eof_in;
      dist_ff     <= dist_in;
      idx_ff      <= idx_in;
      pos_ff      <= pos_in;
      sh_ff       <= sh_in;
      found_ff    <= found_in;
      dup_ff      <= dup_in;
      pend_ff     <= pend_in;
      rsp_ff      <= rsp_in;
      rsp_last_ff <= rsp_last_in;
      rsp_done_ff <= rsp_done_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_deliver    = rsp_ff.deliver;
   assign rsp_out_handle = rsp_ff.handle;
   assign rsp_out_length = rsp_ff.length;
   assign rsp_ack_seq    = rsp_ff.ack;
   assign rsp_dropped    = rsp_ff.dropped;
   assign rsp_done_res   = rsp_done_ff;
   assign rsp_last       = rsp_last_ff;

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(ENTRIES))
      else $error("segment table count exceeds its depth");

   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while the previous one is in progress");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> !req_ready)
      else $error("new request taken before all results of the last one");

endmodule

// ===== rtl/srt_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the segment table of the reorder tracker.
module srt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
